// ===== hdl/closest_pair_min_distance_core_defines.svh =====
// Assertion macros shared by the closest-pair core RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef CLOSEST_PAIR_MIN_DISTANCE_CORE_DEFINES_SVH
`define CLOSEST_PAIR_MIN_DISTANCE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CPMD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("closest-pair core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define CPMD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("closest-pair core: next-cycle check failed");

`endif

// ===== hdl/cpmd_pkg.sv =====
// Shared constants and types for the closest-pair minimum distance core.
// Depends on nothing; imported by the top level and by cpmd_dist.
`timescale 1ns / 1ps

package cpmd_pkg;

    // Set capacity and coordinate precision
    localparam int MaxPoints  = 64;
    localparam int CoordBits  = 16;
    localparam int FieldBits  = 16;
    localparam int CoordW     = (CoordBits < FieldBits) ? CoordBits : FieldBits;

    // Derived widths
    localparam int CntW       = $clog2(MaxPoints + 1);
    localparam int AddrW      = $clog2(MaxPoints);
    localparam int PointW     = 2 * CoordW;
    localparam int DistW      = 2 * CoordW + 1;
    localparam int OutDistW   = 33;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic [DistW-1:0]         dist_t;

    // Result of one distance evaluation
    typedef struct packed {
        logic  valid;
        dist_t dist_sq;
    } dist_out_t;

endpackage

// ===== hdl/closest_pair_min_distance_core.sv =====
// Closest-pair minimum squared distance core: top level.
// Depends on cpmd_pkg, cpmd_ram, cpmd_dist and closest_pair_min_distance_core_defines.svh.
//
// Points of one set arrive one item at a time; s_last_point closes the set and
// produces exactly one result: the least squared distance over all stored pairs,
// no_pair when fewer than two points were stored, and overflowed when points
// beyond the 64-entry store were dropped. A point that finds points already
// stored is accepted, read against each of them in turn through the single
// read port of the point memory, then waits for the pipeline to drain before
// its write-back; a point that finds the store empty goes straight to the
// write-back, and one that finds it full is dropped. A closing point then
// hands its result over. The result waits in an output register; the next
// item is taken while it waits, and a further closing item stalls only until
// that result is taken.
`timescale 1ns / 1ps
`include "closest_pair_min_distance_core_defines.svh"

module closest_pair_min_distance_core
    import cpmd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_point_x,
    input  logic signed [15:0]  s_point_y,
    input  logic                s_last_point,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OutDistW-1:0] m_min_dist_sq,
    output logic                m_no_pair,
    output logic                m_overflowed
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_STORE,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic [CntW-1:0]     rd_idx_reg, rd_idx_next;
    logic                rd_valid_reg;
    dist_t               best_reg, best_next;
    logic                best_valid_reg, best_valid_next;
    logic                ovf_reg, ovf_next;
    coord_t              px_reg, px_next;
    coord_t              py_reg, py_next;
    logic                last_reg, last_next;
    logic                m_valid_reg, m_valid_next;
    logic [OutDistW-1:0] m_dist_reg, m_dist_next;
    logic                m_no_pair_reg, m_no_pair_next;
    logic                m_ovf_reg, m_ovf_next;

    logic                ram_wr_en, ram_rd_en;
    logic [PointW-1:0]   ram_rd_data;
    logic                dist_busy;
    dist_out_t           dist_out;
    logic                out_free;

    // Point store: y in the upper half, x in the lower half
    cpmd_ram #(
        .DataW (PointW),
        .Depth (MaxPoints)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[AddrW-1:0]),
        .wr_data ({py_reg, px_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg[AddrW-1:0]),
        .rd_data (ram_rd_data)
    );

    cpmd_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_valid_reg),
        .px       (px_reg),
        .py       (py_reg),
        .qx       (coord_t'(ram_rd_data[CoordW-1:0])),
        .qy       (coord_t'(ram_rd_data[PointW-1:CoordW])),
        .busy     (dist_busy),
        .dist_out (dist_out)
    );

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer and set state
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        best_next       = best_reg;
        best_valid_next = best_valid_reg;
        ovf_next        = ovf_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        last_next       = last_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_dist_next     = m_dist_reg;
        m_no_pair_next  = m_no_pair_reg;
        m_ovf_next      = m_ovf_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;

        // Fold each finished distance into the running minimum
        if (dist_out.valid && (!best_valid_reg || dist_out.dist_sq < best_reg)) begin
            best_next       = dist_out.dist_sq;
            best_valid_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    px_next   = coord_t'(s_point_x[CoordW-1:0]);
                    py_next   = coord_t'(s_point_y[CoordW-1:0]);
                    last_next = s_last_point;
                    if (count_reg == CntW'(MaxPoints)) begin
                        ovf_next   = 1'b1;
                        state_next = s_last_point ? ST_FINISH : ST_IDLE;
                    end else if (count_reg == '0) begin
                        state_next = ST_STORE;
                    end else begin
                        rd_idx_next = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                ram_rd_en   = 1'b1;
                rd_idx_next = rd_idx_reg + CntW'(1);
                if (rd_idx_reg == count_reg - CntW'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_valid_reg && !dist_busy) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                ram_wr_en  = 1'b1;
                count_next = count_reg + CntW'(1);
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_no_pair_next  = (count_reg < CntW'(2));
                    m_dist_next     = (count_reg < CntW'(2)) ? '0 : OutDistW'(best_reg);
                    m_ovf_next      = ovf_reg;
                    count_next      = '0;
                    best_valid_next = 1'b0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            best_valid_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            best_valid_reg <= best_valid_next;
            ovf_reg        <= ovf_next;
            rd_valid_reg   <= ram_rd_en;
            m_valid_reg    <= m_valid_next;
        end
        rd_idx_reg    <= rd_idx_next;
        best_reg      <= best_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        last_reg      <= last_next;
        m_dist_reg    <= m_dist_next;
        m_no_pair_reg <= m_no_pair_next;
        m_ovf_reg     <= m_ovf_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_min_dist_sq = m_dist_reg;
    assign m_no_pair     = m_no_pair_reg;
    assign m_overflowed  = m_ovf_reg;

    // Checks
    `CPMD_ASSERT_NOW(a_wr_in_range, aclk, aresetn, ram_wr_en, count_reg < CntW'(MaxPoints))
    `CPMD_ASSERT_NOW(a_rd_in_range, aclk, aresetn, ram_rd_en, rd_idx_reg < count_reg)
    `CPMD_ASSERT_NOW(a_idle_quiet, aclk, aresetn, s_ready, !rd_valid_reg && !dist_busy)
    `CPMD_ASSERT_NEXT(a_finish_clears, aclk, aresetn, (state_reg == ST_FINISH) && out_free, m_valid && count_reg == '0)

endmodule

// ===== hdl/cpmd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module cpmd_ram #(
    parameter int DataW = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [DataW-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [DataW-1:0]         rd_data
);

    logic [DataW-1:0] mem [Depth];
    logic [DataW-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/cpmd_dist.sv =====
// Three-stage squared-distance pipeline: abs difference, squares, sum.
// Depends on cpmd_pkg.
`timescale 1ns / 1ps

module cpmd_dist
    import cpmd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  coord_t    px,
    input  coord_t    py,
    input  coord_t    qx,
    input  coord_t    qy,
    output logic      busy,
    output dist_out_t dist_out
);

    logic signed [CoordW:0] dx, dy;
    logic [CoordW-1:0]      adx, ady;

    logic                   v1_reg, v2_reg, v3_reg;
    logic [CoordW-1:0]      adx_reg, ady_reg;
    logic [2*CoordW-1:0]    sqx_reg, sqy_reg;
    dist_t                  sum_reg;

    // Magnitude of each difference fits in CoordW bits
    always_comb begin
        dx  = {px[CoordW-1], px} - {qx[CoordW-1], qx};
        dy  = {py[CoordW-1], py} - {qy[CoordW-1], qy};
        adx = dx[CoordW] ? CoordW'(-dx) : CoordW'(dx);
        ady = dy[CoordW] ? CoordW'(-dy) : CoordW'(dy);
    end

    // Advance valid tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Datapath stages
    always_ff @(posedge aclk) begin
        adx_reg <= adx;
        ady_reg <= ady;
        sqx_reg <= adx_reg * adx_reg;
        sqy_reg <= ady_reg * ady_reg;
        sum_reg <= DistW'(sqx_reg) + DistW'(sqy_reg);
    end

    assign busy             = v1_reg | v2_reg | v3_reg;
    assign dist_out.valid   = v3_reg;
    assign dist_out.dist_sq = sum_reg;

endmodule
